@@ rtl/core/sts_pkg.sv @@
// Package for the sphere triangle subdivider: widths, latencies and vector types.
// No dependencies; used by every module of the block.
`default_nettype none
package sts_pkg;
  localparam int CoordWidth = 16;
  localparam int FracBits = 14;
  localparam int MagWidth = CoordWidth + 1;
  localparam int PosWidth = $clog2(MagWidth);
  localparam int NormWidth = 31;
  localparam int NormTop = NormWidth - 1;
  localparam int ShWidth = MagWidth + NormTop;
  localparam int SqWidth = 64;
  localparam int RootWidth = 32;
  localparam int RemWidth = RootWidth + 4;
  localparam int QuoWidth = FracBits + 2;
  localparam int NumWidth = FracBits + NormWidth + 1;
  localparam int DivRemWidth = RootWidth + 1;
  localparam int CmpWidth = QuoWidth + CoordWidth;
  localparam int LaneLat = RootWidth + QuoWidth + 7;
  localparam int ResultsPerItem = 4;
  localparam int CntWidth = $clog2(ResultsPerItem);
  localparam logic [CntWidth-1:0] LastPhase = CntWidth'(ResultsPerItem - 1);
  localparam logic [CoordWidth-1:0] CoordMaxPos = {1'b0, {(CoordWidth-1){1'b1}}};

  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][CoordWidth-1:0] vec_t;

  typedef struct packed {
    logic [2:0][NormWidth-1:0] nrm;
    logic [2:0]                neg;
    logic                      zero;
  } carry_t;

  typedef struct packed {
    vec_t p1;
    vec_t p2;
    vec_t p3;
    vec_t m12;
    vec_t m13;
    vec_t m23;
  } tri_set_t;
endpackage
`default_nettype wire

@@ rtl/core/sts_lane.sv @@
// One projection lane: edge sum, normalisation, pipelined square root and
// three pipelined dividers. Depends on sts_pkg.
`default_nettype none
module sts_lane (
  input  wire logic          clk_i,
  input  wire sts_pkg::vec_t u_i,
  input  wire sts_pkg::vec_t v_i,
  output sts_pkg::vec_t      r_o
);
  logic [2:0][sts_pkg::MagWidth-1:0] mag_d, mag_q, mag2_q;
  logic [2:0] neg_d, neg_q, neg2_q, neg3_q;
  logic [sts_pkg::MagWidth-1:0] orv;
  logic [sts_pkg::PosWidth-1:0] pos_d, pos_q;
  logic zero_q, zero3_q;
  logic [2:0][sts_pkg::NormWidth-1:0] nrm_d, nrm3_q;
  logic [2:0][2*sts_pkg::NormWidth-1:0] sq4_q;
  sts_pkg::carry_t c4_q;

  logic [sts_pkg::RemWidth-1:0]  sq_rem  [sts_pkg::RootWidth+1];
  logic [sts_pkg::RootWidth-1:0] sq_root [sts_pkg::RootWidth+1];
  logic [sts_pkg::SqWidth-1:0]   sq_val  [sts_pkg::RootWidth+1];
  sts_pkg::carry_t               sq_c    [sts_pkg::RootWidth+1];

  logic [2:0][sts_pkg::DivRemWidth-1:0] dv_rem [sts_pkg::QuoWidth+1];
  logic [2:0][sts_pkg::NumWidth-1:0]    dv_num [sts_pkg::QuoWidth+1];
  logic [2:0][sts_pkg::QuoWidth-1:0]    dv_quo [sts_pkg::QuoWidth+1];
  logic [sts_pkg::RootWidth-1:0]        dv_len [sts_pkg::QuoWidth+1];
  logic [2:0]                           dv_neg [sts_pkg::QuoWidth+1];
  logic                                 dv_zero[sts_pkg::QuoWidth+1];
  logic [2:0][sts_pkg::NumWidth-1:0]    num_d;
  sts_pkg::vec_t r_d, r_q;

  // Edge sum magnitudes; the halving of the midpoint cancels out.
  always_comb begin
    logic [sts_pkg::MagWidth-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {u_i[i][sts_pkg::CoordWidth-1], u_i[i]} + {v_i[i][sts_pkg::CoordWidth-1], v_i[i]};
      neg_d[i] = s[sts_pkg::MagWidth-1];
      mag_d[i] = s[sts_pkg::MagWidth-1] ? (~s + 1'b1) : s;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  // The top set bit of the OR of the magnitudes is the top bit of the largest.
  always_comb begin
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    pos_d = '0;
    for (int b = 0; b < sts_pkg::MagWidth; b++) begin
      if (orv[b]) pos_d = sts_pkg::PosWidth'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    zero_q <= (orv == '0);
    mag2_q <= mag_q;
    neg2_q <= neg_q;
  end

  always_comb begin
    logic [sts_pkg::ShWidth-1:0] w;
    for (int i = 0; i < 3; i++) begin
      w = {mag2_q[i], {sts_pkg::NormTop{1'b0}}} >> pos_q;
      nrm_d[i] = w[sts_pkg::NormWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm3_q  <= nrm_d;
    neg3_q  <= neg2_q;
    zero3_q <= zero_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) sq4_q[i] <= nrm3_q[i] * nrm3_q[i];
    c4_q.nrm  <= nrm3_q;
    c4_q.neg  <= neg3_q;
    c4_q.zero <= zero3_q;
  end

  always_ff @(posedge clk_i) begin
    sq_val[0]  <= sts_pkg::SqWidth'(sq4_q[0]) + sts_pkg::SqWidth'(sq4_q[1])
                + sts_pkg::SqWidth'(sq4_q[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_c[0]    <= c4_q;
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < sts_pkg::RootWidth; k++) begin : g_sqrt
    logic [sts_pkg::RemWidth-1:0] rem_t, trial;
    logic ge;
    always_comb begin
      rem_t = {sq_rem[k][sts_pkg::RemWidth-3:0], sq_val[k][sts_pkg::SqWidth-1-2*k -: 2]};
      trial = {2'b00, sq_root[k], 2'b01};
      ge = rem_t >= trial;
    end
    always_ff @(posedge clk_i) begin
      sq_rem[k+1]  <= ge ? rem_t - trial : rem_t;
      sq_root[k+1] <= {sq_root[k][sts_pkg::RootWidth-2:0], ge};
      sq_val[k+1]  <= sq_val[k];
      sq_c[k+1]    <= sq_c[k];
    end
  end

  // Dividend carries half the length so that the quotient rounds half up.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = sts_pkg::NumWidth'({sq_c[sts_pkg::RootWidth].nrm[i],
                                     {sts_pkg::FracBits{1'b0}}})
               + sts_pkg::NumWidth'(sq_root[sts_pkg::RootWidth][sts_pkg::RootWidth-1:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= sts_pkg::DivRemWidth'(num_d[i][sts_pkg::NumWidth-1:sts_pkg::QuoWidth]);
    end
    dv_num[0]  <= num_d;
    dv_quo[0]  <= '0;
    dv_len[0]  <= sq_root[sts_pkg::RootWidth];
    dv_neg[0]  <= sq_c[sts_pkg::RootWidth].neg;
    dv_zero[0] <= sq_c[sts_pkg::RootWidth].zero;
  end

  for (genvar j = 0; j < sts_pkg::QuoWidth; j++) begin : g_div
    logic [2:0][sts_pkg::DivRemWidth-1:0] t;
    logic [2:0] ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dv_rem[j][i][sts_pkg::DivRemWidth-2:0], dv_num[j][i][sts_pkg::QuoWidth-1-j]};
        ge[i] = t[i] >= {1'b0, dv_len[j]};
      end
    end
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[j+1][i] <= ge[i] ? t[i] - {1'b0, dv_len[j]} : t[i];
        dv_quo[j+1][i] <= {dv_quo[j][i][sts_pkg::QuoWidth-2:0], ge[i]};
      end
      dv_num[j+1]  <= dv_num[j];
      dv_len[j+1]  <= dv_len[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_zero[j+1] <= dv_zero[j];
    end
  end

  always_comb begin
    logic [sts_pkg::CoordWidth-1:0] m;
    for (int i = 0; i < 3; i++) begin
      if (sts_pkg::CmpWidth'(dv_quo[sts_pkg::QuoWidth][i]) >
          sts_pkg::CmpWidth'(sts_pkg::CoordMaxPos)) begin
        m = sts_pkg::CoordMaxPos;
      end else begin
        m = sts_pkg::CoordWidth'(dv_quo[sts_pkg::QuoWidth][i]);
      end
      if (dv_zero[sts_pkg::QuoWidth]) r_d[i] = '0;
      else r_d[i] = dv_neg[sts_pkg::QuoWidth][i] ? (~m + 1'b1) : m;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign r_o = r_q;
endmodule
`default_nettype wire

@@ rtl/core/sts_merge.sv @@
// Merging stage: gathers the corners and the three projected midpoints and
// issues the four sub-triangles on consecutive cycles. Depends on sts_pkg.
`default_nettype none
module sts_merge (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire sts_pkg::tri_set_t set_i,
  output logic                   valid_o,
  output logic                   last_o,
  output sts_pkg::vec_t          a_o,
  output sts_pkg::vec_t          b_o,
  output sts_pkg::vec_t          c_o
);
  sts_pkg::tri_set_t set_q;
  logic active_q;
  logic [sts_pkg::CntWidth-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (load_i) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (active_q) begin
      if (cnt_q == sts_pkg::LastPhase) active_q <= 1'b0;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) set_q <= set_i;
  end

  always_comb begin
    case (cnt_q)
      2'd0: begin
        a_o = set_q.p1;  b_o = set_q.m12; c_o = set_q.m13;
      end
      2'd1: begin
        a_o = set_q.p2;  b_o = set_q.m23; c_o = set_q.m12;
      end
      2'd2: begin
        a_o = set_q.m12; b_o = set_q.m23; c_o = set_q.m13;
      end
      default: begin
        a_o = set_q.m23; b_o = set_q.p3;  c_o = set_q.m13;
      end
    endcase
  end

  assign valid_o = active_q;
  assign last_o  = active_q && (cnt_q == sts_pkg::LastPhase);
endmodule
`default_nettype wire

@@ rtl/core/sphere_triangle_subdivider.sv @@
// Top level of the sphere triangle subdivider: three projection lanes and the
// merging stage. Depends on sts_pkg, sts_lane and sts_merge.
//
// A triangle is taken when start_i is high and busy_o low; busy_o then stays
// high while an internal pace counter counts down to zero, so further
// triangles can enter while earlier ones are still in the lanes. The four
// sub-triangles leave on consecutive cycles, marked by out_valid_o. Each lane
// holds a square-root pipeline and dividers, one bit per stage in both.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module sphere_triangle_subdivider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] a_x_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] a_y_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] a_z_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] b_x_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] b_y_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] b_z_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] c_x_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] c_y_i,
  input  wire logic signed [sts_pkg::CoordWidth-1:0] c_z_i,
  output logic             out_valid_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_a_x_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_a_y_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_a_z_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_b_x_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_b_y_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_b_z_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_c_x_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_c_y_o,
  output logic signed [sts_pkg::CoordWidth-1:0] out_c_z_o,
  output logic             last_of_four_o
);
  sts_pkg::vec_t p1, p2, p3, m12, m13, m23, ra, rb, rc;
  sts_pkg::vec_t cor_q [sts_pkg::LaneLat][3];
  logic [sts_pkg::LaneLat-1:0] vld_q;
  logic [sts_pkg::CntWidth-1:0] pace_q;
  logic accept;
  sts_pkg::tri_set_t set;

  assign p1 = {a_z_i, a_y_i, a_x_i};
  assign p2 = {b_z_i, b_y_i, b_x_i};
  assign p3 = {c_z_i, c_y_i, c_x_i};
  assign accept = start_i && !busy_o;
  assign busy_o = (pace_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pace_q <= '0;
      vld_q  <= '0;
    end else begin
      if (accept) pace_q <= sts_pkg::LastPhase;
      else if (pace_q != '0) pace_q <= pace_q - 1'b1;
      vld_q <= {vld_q[sts_pkg::LaneLat-2:0], accept};
    end
  end

  // Corners ride alongside the lanes.
  always_ff @(posedge clk_i) begin
    cor_q[0][0] <= p1;
    cor_q[0][1] <= p2;
    cor_q[0][2] <= p3;
    for (int j = 1; j < sts_pkg::LaneLat; j++) cor_q[j] <= cor_q[j-1];
  end

  sts_lane u_lane12 (.clk_i(clk_i), .u_i(p1), .v_i(p2), .r_o(m12));
  sts_lane u_lane13 (.clk_i(clk_i), .u_i(p1), .v_i(p3), .r_o(m13));
  sts_lane u_lane23 (.clk_i(clk_i), .u_i(p3), .v_i(p2), .r_o(m23));

  always_comb begin
    set.p1  = cor_q[sts_pkg::LaneLat-1][0];
    set.p2  = cor_q[sts_pkg::LaneLat-1][1];
    set.p3  = cor_q[sts_pkg::LaneLat-1][2];
    set.m12 = m12;
    set.m13 = m13;
    set.m23 = m23;
  end

  sts_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (vld_q[sts_pkg::LaneLat-1]),
    .set_i  (set),
    .valid_o(out_valid_o),
    .last_o (last_of_four_o),
    .a_o    (ra),
    .b_o    (rb),
    .c_o    (rc)
  );

  assign out_a_x_o = ra[0];
  assign out_a_y_o = ra[1];
  assign out_a_z_o = ra[2];
  assign out_b_x_o = rb[0];
  assign out_b_y_o = rb[1];
  assign out_b_z_o = rb[2];
  assign out_c_x_o = rc[0];
  assign out_c_y_o = rc[1];
  assign out_c_z_o = rc[2];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy not raised after an item was taken");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[sts_pkg::LaneLat-1] |-> (!out_valid_o || last_of_four_o))
    else $error("lane result arrived while the merging stage was still issuing");

  a_four_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_four_o |-> ($past(out_valid_o, 1) && $past(out_valid_o, 3)))
    else $error("last sub-triangle not preceded by three results");

  a_pace_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (vld_q[2:0] == '0)) else $error("items taken closer than four cycles");
endmodule
`default_nettype wire
